/* rtl/core/pmfd_pkg.sv */
// Shared constants, types and codes for the packed monochrome frame store.
`default_nettype none

package pmfd_pkg;

   localparam int PANEL_WIDTH  = 168;
   localparam int PANEL_HEIGHT = 384;
   localparam int ROW_BYTES    = (PANEL_WIDTH + 3) / 4;
   localparam int BYTE_ROWS    = (PANEL_HEIGHT + 1) / 2;
   localparam int STORE_LEN    = ROW_BYTES * BYTE_ROWS;
   localparam int AW           = $clog2(STORE_LEN);
   localparam int COORD_MAX    = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
   localparam int COORD_W      = $clog2(COORD_MAX);

   typedef enum logic [2:0] {
      OP_POINT = 3'd0,
      OP_HRUN  = 3'd1,
      OP_VRUN  = 3'd2,
      OP_FILL  = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_START,
      ST_RD,
      ST_MOD,
      ST_FILL,
      ST_RDB,
      ST_RDW,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [15:0] x_start;
      logic signed [15:0] x_end;
      logic signed [15:0] y_start;
      logic signed [15:0] y_end;
      logic               pixel_on;
      logic [7:0]         fill_value;
      logic [12:0]        byte_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       nothing_written;
   } rsp_type;

   typedef struct packed {
      logic [AW-1:0] addr;
      logic [AW-1:0] step;
      logic [AW-1:0] cnt;
      logic [AW-1:0] last;
   } step_in_type;

   typedef struct packed {
      logic [AW-1:0] addr_next;
      logic [AW-1:0] cnt_next;
      logic          at_last;
   } step_out_type;

endpackage

`default_nettype wire

/* rtl/core/pmfd_store.sv */
// Frame store: one write port, one read port with registered read data.
`default_nettype none

module pmfd_store import pmfd_pkg::*; (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [STORE_LEN];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pmfd_step.sv */
// Shared address stepper: advances address and byte count, flags the last byte.
`default_nettype none

module pmfd_step import pmfd_pkg::*; (
   input  step_in_type  step_in,
   output step_out_type step_out
);

   always_comb begin
      step_out.addr_next = step_in.addr + step_in.step;
      step_out.cnt_next  = step_in.cnt + AW'(1);
      step_out.at_last   = (step_in.cnt == step_in.last);
   end

endmodule

`default_nettype wire

/* rtl/core/pmfd_seq.sv */
// Sequencer: decodes a request, clips runs, and walks the store byte by byte.
`default_nettype none

module pmfd_seq import pmfd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req,
   output logic    ready,
   input  logic    rsp_free,
   output logic    done,
   output rsp_type result
);

   localparam logic signed [15:0] WIDTH_S  = 16'(PANEL_WIDTH);
   localparam logic signed [15:0] HEIGHT_S = 16'(PANEL_HEIGHT);

   state_type state_ff, state_in;

   logic [2:0]         op_ff, op_in;
   logic               on_ff, on_in;
   logic [7:0]         fv_ff, fv_in;
   logic [12:0]        bi_ff, bi_in;
   logic signed [15:0] xs_ff, xs_in, xe_ff, xe_in, ys_ff, ys_in, ye_ff, ye_in;
   logic               horiz_ff, horiz_in;
   logic [COORD_W-1:0] fix_ff, fix_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]      addr_ff, addr_in, cnt_ff, cnt_in, last_ff, last_in;
   logic [AW-1:0]      step_ff, step_in;
   logic               first_ff, first_in;
   logic [7:0]         rd_ff, rd_in;
   logic               none_ff, none_in;

   logic               horiz_s, in_panel;
   logic signed [15:0] a_s, b_s, fix_s, lo_s, hi_s, fix_lim, along_lim, lo_clip, hi_clip;
   logic [AW-1:0]      row_s, col_s, first_cnt, last_cnt, start_addr;
   logic [7:0]         mask, mod_data, rdata;

   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [7:0]         mem_wdata;

   step_in_type        stp_in;
   step_out_type       stp_out;

   // bits of one tile byte touched by the current step of a run
   function automatic logic [7:0] tile_mask(input logic horiz, input logic [1:0] fix2,
                                            input logic [1:0] lo2, input logic [1:0] hi2,
                                            input logic first, input logic last);
      logic [7:0] m;
      logic [2:0] pos;
      m = '0;
      if (horiz) begin
         for (int i = 0; i < 4; i++) begin
            if ((!first || i >= lo2) && (!last || i <= hi2)) begin
               pos = 3'(2 * i) + {2'b00, fix2[0]};
               m[3'd7 - pos] = 1'b1;
            end
         end
      end else begin
         for (int p = 0; p < 2; p++) begin
            if ((!first || p >= lo2[0]) && (!last || p <= hi2[0])) begin
               pos = {fix2, 1'b0} + 3'(p);
               m[3'd7 - pos] = 1'b1;
            end
         end
      end
      return m;
   endfunction

   pmfd_step u_step (
      .step_in  (stp_in),
      .step_out (stp_out)
   );

   pmfd_store u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (rdata)
   );

   assign stp_in = '{addr: addr_ff, step: step_ff, cnt: cnt_ff, last: last_ff};
   assign ready  = (state_ff == ST_IDLE);
   assign done   = (state_ff == ST_DONE);
   assign result = '{read_data: rd_ff, nothing_written: none_ff};

   // run geometry: a point is a horizontal run of one pixel
   always_comb begin
      horiz_s   = (op_ff != OP_VRUN);
      a_s       = horiz_s ? xs_ff : ys_ff;
      b_s       = (op_ff == OP_HRUN) ? xe_ff : ((op_ff == OP_VRUN) ? ye_ff : xs_ff);
      fix_s     = horiz_s ? ys_ff : xs_ff;
      fix_lim   = horiz_s ? HEIGHT_S : WIDTH_S;
      along_lim = horiz_s ? WIDTH_S : HEIGHT_S;
      lo_s      = (a_s > b_s) ? b_s : a_s;
      hi_s      = (a_s > b_s) ? a_s : b_s;
      in_panel  = (fix_s >= 16'sd0) && (fix_s < fix_lim) && (lo_s < along_lim)
                  && (hi_s >= 16'sd0);
      lo_clip   = (lo_s < 16'sd0) ? 16'sd0 : lo_s;
      hi_clip   = (hi_s >= along_lim) ? (along_lim - 16'sd1) : hi_s;

      row_s      = horiz_ff ? AW'(fix_ff >> 1) : AW'(lo_ff >> 1);
      col_s      = horiz_ff ? AW'(lo_ff >> 2) : AW'(fix_ff >> 2);
      first_cnt  = horiz_ff ? AW'(lo_ff >> 2) : AW'(lo_ff >> 1);
      last_cnt   = horiz_ff ? AW'(hi_ff >> 2) : AW'(hi_ff >> 1);
      start_addr = row_s * AW'(ROW_BYTES) + col_s;

      mask     = tile_mask(horiz_ff, fix_ff[1:0], lo_ff[1:0], hi_ff[1:0], first_ff,
                           stp_out.at_last);
      mod_data = on_ff ? (rdata | mask) : (rdata & ~mask);
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      on_in     = on_ff;
      fv_in     = fv_ff;
      bi_in     = bi_ff;
      xs_in     = xs_ff;
      xe_in     = xe_ff;
      ys_in     = ys_ff;
      ye_in     = ye_ff;
      horiz_in  = horiz_ff;
      fix_in    = fix_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      step_in   = step_ff;
      first_in  = first_ff;
      rd_in     = rd_ff;
      none_in   = none_ff;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = fv_ff;
      mem_re    = 1'b0;
      mem_raddr = addr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req.op;
               on_in    = req.pixel_on;
               fv_in    = req.fill_value;
               bi_in    = req.byte_index;
               xs_in    = req.x_start;
               xe_in    = req.x_end;
               ys_in    = req.y_start;
               ye_in    = req.y_end;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            rd_in = 8'd0;
            case (op_type'(op_ff))
               OP_POINT, OP_HRUN, OP_VRUN: begin
                  horiz_in = horiz_s;
                  fix_in   = COORD_W'(fix_s);
                  lo_in    = COORD_W'(lo_clip);
                  hi_in    = COORD_W'(hi_clip);
                  none_in  = !in_panel;
                  state_in = in_panel ? ST_START : ST_DONE;
               end
               OP_FILL: begin
                  addr_in  = '0;
                  cnt_in   = '0;
                  last_in  = AW'(STORE_LEN - 1);
                  step_in  = AW'(1);
                  none_in  = 1'b0;
                  state_in = ST_FILL;
               end
               OP_READ: begin
                  none_in  = !(int'(bi_ff) < STORE_LEN);
                  state_in = (int'(bi_ff) < STORE_LEN) ? ST_RDB : ST_DONE;
               end
               default: begin
                  none_in  = 1'b1;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_START: begin
            addr_in  = start_addr;
            cnt_in   = first_cnt;
            last_in  = last_cnt;
            step_in  = horiz_ff ? AW'(1) : AW'(ROW_BYTES);
            first_in = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            mem_re   = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            // write this byte back while fetching the next one
            mem_we    = 1'b1;
            mem_wdata = mod_data;
            first_in  = 1'b0;
            if (stp_out.at_last) begin
               state_in = ST_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = stp_out.addr_next;
               addr_in   = stp_out.addr_next;
               cnt_in    = stp_out.cnt_next;
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (stp_out.at_last) begin
               state_in = ST_DONE;
            end else begin
               addr_in = stp_out.addr_next;
               cnt_in  = stp_out.cnt_next;
            end
         end
         ST_RDB: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(bi_ff);
            state_in  = ST_RDW;
         end
         ST_RDW: begin
            rd_in    = rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      on_ff    <= on_in;
      fv_ff    <= fv_in;
      bi_ff    <= bi_in;
      xs_ff    <= xs_in;
      xe_ff    <= xe_in;
      ys_ff    <= ys_in;
      ye_ff    <= ye_in;
      horiz_ff <= horiz_in;
      fix_ff   <= fix_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      addr_ff  <= addr_in;
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
      step_ff  <= step_in;
      first_ff <= first_in;
      rd_ff    <= rd_in;
      none_ff  <= none_in;
   end

`ifndef SYNTHESIS
   a_start_setup: assert property (@(posedge clock) disable iff (reset)
      start |=> state_ff == ST_SETUP)
      else $error("request accepted but decode did not follow");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_free) |=> (state_ff == ST_DONE && $stable(result)))
      else $error("finished result lost while output slot busy");

   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (int'(mem_waddr) < STORE_LEN))
      else $error("store write beyond end");

   a_rd_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |=> (state_ff == ST_MOD && first_ff))
      else $error("byte fetch not followed by first modify");
`endif

endmodule

`default_nettype wire

/* rtl/core/packed_mono_framebuffer_draw.sv */
// Top level: request intake, sequencer and registered response slot.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid / req_stall | op, x/y ends, pixel_on, fill_value, byte_index
//   rsp     | out       | rsp_valid / rsp_stall | read_data, nothing_written
//
// One request at a time. A point or run does one store read-modify-write per cycle
// after the first fetch; fill writes the store byte by byte; a read fetches one byte.
// Out-of-panel runs, reads past the store and unknown ops finish without touching
// the store. Each request returns the sequencer to idle before the next is taken.
// The byte walk overlaps the store's separate read and write ports.
// Synchronous reset returns the sequencer to idle; store contents are kept.
// A new request is taken while an earlier response waits under rsp_stall.
`default_nettype none

module packed_mono_framebuffer_draw import pmfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic signed [15:0] req_x_start,
   input  logic signed [15:0] req_x_end,
   input  logic signed [15:0] req_y_start,
   input  logic signed [15:0] req_y_end,
   input  logic               req_pixel_on,
   input  logic [7:0]         req_fill_value,
   input  logic [12:0]        req_byte_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_nothing_written
);

   req_type    req;
   rsp_type    seq_result;
   logic       seq_ready, seq_done, rsp_free, start;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_none_ff, rsp_none_in;

   assign req = '{op: req_op, x_start: req_x_start, x_end: req_x_end,
                  y_start: req_y_start, y_end: req_y_end, pixel_on: req_pixel_on,
                  fill_value: req_fill_value, byte_index: req_byte_index};

   assign req_stall = !seq_ready;
   assign start     = req_valid && seq_ready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   pmfd_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req),
      .ready    (seq_ready),
      .rsp_free (rsp_free),
      .done     (seq_done),
      .result   (seq_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_none_in  = rsp_none_ff;
      if (seq_done && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result.read_data;
         rsp_none_in  = seq_result.nothing_written;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_data_ff;
   assign rsp_nothing_written = rsp_none_ff;

endmodule

`default_nettype wire

/* test/tb_packed_mono_framebuffer_draw.sv */
// Self-checking testbench for the packed monochrome frame store draw engine.
`default_nettype none

module tb_packed_mono_framebuffer_draw;
   import pmfd_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_op;
   logic signed [15:0] req_x_start;
   logic signed [15:0] req_x_end;
   logic signed [15:0] req_y_start;
   logic signed [15:0] req_y_end;
   logic               req_pixel_on;
   logic [7:0]         req_fill_value;
   logic [12:0]        req_byte_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [7:0]         rsp_read_data;
   logic               rsp_nothing_written;

   packed_mono_framebuffer_draw u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_x_start         (req_x_start),
      .req_x_end           (req_x_end),
      .req_y_start         (req_y_start),
      .req_y_end           (req_y_end),
      .req_pixel_on        (req_pixel_on),
      .req_fill_value      (req_fill_value),
      .req_byte_index      (req_byte_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .rsp_nothing_written (rsp_nothing_written)
   );

   // shadow copy of the frame store and the responses it predicts
   logic [7:0] shadow_frame [STORE_LEN];
   rsp_type    owed_rsp [$];
   int         last_touched;
   int         error_count;
   int         checked_count;
   int         op_count [8];
   bit         steady;
   bit         rsp_taken;
   int         stall_left;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic void plot(int x, int y, bit on);
      int idx;
      int bpos;
      idx  = (y / 2) * ROW_BYTES + x / 4;
      bpos = 7 - ((x % 4) * 2 + y % 2);
      if (idx < STORE_LEN) begin
         shadow_frame[idx][bpos] = on;
         last_touched = idx;
      end
   endfunction

   // returns 1 if any pixel of the run landed on the panel
   function automatic bit draw_span(int fixed, int fixed_lim, int a0, int a1,
                                    int along_lim, bit horiz, bit on);
      int lo;
      int hi;
      if (fixed < 0 || fixed >= fixed_lim) return 1'b0;
      lo = (a0 < a1) ? a0 : a1;
      hi = (a0 < a1) ? a1 : a0;
      if (lo >= along_lim || hi < 0) return 1'b0;
      if (lo < 0) lo = 0;
      if (hi >= along_lim) hi = along_lim - 1;
      for (int a = lo; a <= hi; a++) begin
         if (horiz) plot(a, fixed, on);
         else plot(fixed, a, on);
      end
      return 1'b1;
   endfunction

   function automatic rsp_type frame_apply(req_type r);
      rsp_type res;
      int      xs;
      int      xe;
      int      ys;
      int      ye;
      xs = int'($signed(r.x_start));
      xe = int'($signed(r.x_end));
      ys = int'($signed(r.y_start));
      ye = int'($signed(r.y_end));
      res.read_data       = '0;
      res.nothing_written = 1'b1;
      case (r.op)
         OP_POINT: begin
            if (xs >= 0 && xs < PANEL_WIDTH && ys >= 0 && ys < PANEL_HEIGHT) begin
               plot(xs, ys, r.pixel_on);
               res.nothing_written = 1'b0;
            end
         end
         OP_HRUN:
            res.nothing_written = !draw_span(ys, PANEL_HEIGHT, xs, xe, PANEL_WIDTH,
                                             1'b1, r.pixel_on);
         OP_VRUN:
            res.nothing_written = !draw_span(xs, PANEL_WIDTH, ys, ye, PANEL_HEIGHT,
                                             1'b0, r.pixel_on);
         OP_FILL: begin
            foreach (shadow_frame[i]) shadow_frame[i] = r.fill_value;
            res.nothing_written = 1'b0;
         end
         OP_READ: begin
            if (int'(r.byte_index) < STORE_LEN) begin
               res.read_data       = shadow_frame[r.byte_index];
               res.nothing_written = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- driving

   function automatic req_type make_req(logic [2:0] op, int xs, int xe, int ys, int ye,
                                        bit on, int fv, int bi);
      req_type r;
      r.op         = op;
      r.x_start    = 16'(xs);
      r.x_end      = 16'(xe);
      r.y_start    = 16'(ys);
      r.y_end      = 16'(ye);
      r.pixel_on   = on;
      r.fill_value = 8'(fv);
      r.byte_index = 13'(bi);
      return r;
   endfunction

   // caller is at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(req_type r);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op         = r.op;
      req_x_start    = r.x_start;
      req_x_end      = r.x_end;
      req_y_start    = r.y_start;
      req_y_end      = r.y_end;
      req_pixel_on   = r.pixel_on;
      req_fill_value = r.fill_value;
      req_byte_index = r.byte_index;
      req_valid      = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      owed_rsp.push_back(frame_apply(r));
      op_count[r.op]++;
      @(negedge clock);
   endtask

   task automatic wait_all_answered();
      req_valid = 1'b0;
      while (owed_rsp.size() != 0) @(negedge clock);
   endtask

   // mostly on the panel, some just past the edges, some anywhere in 16 bits
   function automatic int pick_coord(int lim);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 8) return $urandom_range(0, lim - 1);
      if (sel == 8) return int'($urandom_range(0, lim + 5)) - 3;
      return int'($signed(16'($urandom)));
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      sel;
      r   = make_req(3'($urandom), $urandom, $urandom, $urandom, $urandom,
                     1'($urandom), $urandom, $urandom);
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         r.op      = OP_POINT;
         r.x_start = 16'(pick_coord(PANEL_WIDTH));
         r.y_start = 16'(pick_coord(PANEL_HEIGHT));
      end else if (sel < 52) begin
         r.op      = OP_HRUN;
         r.y_start = 16'(pick_coord(PANEL_HEIGHT));
         r.x_start = 16'(pick_coord(PANEL_WIDTH));
         r.x_end   = 16'(pick_coord(PANEL_WIDTH));
      end else if (sel < 67) begin
         r.op      = OP_VRUN;
         r.x_start = 16'(pick_coord(PANEL_WIDTH));
         r.y_start = 16'(pick_coord(PANEL_HEIGHT));
         r.y_end   = 16'(pick_coord(PANEL_HEIGHT));
      end else if (sel < 93) begin
         r.op = OP_READ;
         case ($urandom_range(0, 9))
            0:       r.byte_index = 13'($urandom);
            1, 2, 3: r.byte_index = 13'($urandom_range(0, STORE_LEN - 1));
            default: r.byte_index = 13'(last_touched);
         endcase
      end else if (sel < 95) begin
         r.op = OP_FILL;
      end else if (sel < 97) begin
         r.op = 3'(int'(OP_READ) + $urandom_range(1, 3));
      end
      // remaining share keeps the fully random fields as noise
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = 1'b1;
         if (owed_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = owed_rsp.pop_front();
            checked_count++;
            if (rsp_read_data !== want.read_data)
               report_mismatch($sformatf("read_data got %02h want %02h",
                                         rsp_read_data, want.read_data));
            if (rsp_nothing_written !== want.nothing_written)
               report_mismatch($sformatf("nothing_written got %b want %b",
                                         rsp_nothing_written, want.nothing_written));
         end
      end
   end

   // stall after each response for a drawn number of cycles
   always @(negedge clock) begin
      if (rsp_taken) begin
         stall_left = draw_wait();
         rsp_taken  = 1'b0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      // nothing in the store is defined yet: only requests that touch nothing until the fill
      send_request(make_req(OP_POINT, -1, $urandom, 0, $urandom, 1'b1, $urandom, $urandom));
      send_request(make_req(OP_POINT, PANEL_WIDTH, $urandom, 0, $urandom, 1'b1, $urandom,
                            $urandom));
      send_request(make_req(OP_POINT, 0, $urandom, -32768, $urandom, 1'b0, $urandom,
                            $urandom));
      send_request(make_req(OP_POINT, 32767, $urandom, PANEL_HEIGHT, $urandom, 1'b1,
                            $urandom, $urandom));
      send_request(make_req(OP_HRUN, 0, PANEL_WIDTH - 1, -1, $urandom, 1'b1, $urandom,
                            $urandom));
      send_request(make_req(OP_VRUN, PANEL_WIDTH, $urandom, 0, PANEL_HEIGHT - 1, 1'b1,
                            $urandom, $urandom));
      for (int k = int'(OP_READ) + 1; k < 8; k++)
         send_request(make_req(3'(k), $urandom, $urandom, $urandom, $urandom, 1'($urandom),
                               $urandom, $urandom));
      send_request(make_req(OP_READ, $urandom, $urandom, $urandom, $urandom, 1'b0, $urandom,
                            STORE_LEN));
      send_request(make_req(OP_READ, $urandom, $urandom, $urandom, $urandom, 1'b1, $urandom,
                            8191));
      send_request(make_req(OP_FILL, $urandom, $urandom, $urandom, $urandom, 1'b0, 8'hA5,
                            $urandom));
      send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0, 0, 0));
      send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0, 0, STORE_LEN - 1));
      send_request(make_req(OP_POINT, 0, 0, 0, 0, 1'b1, 0, 0));
      send_request(make_req(OP_POINT, PANEL_WIDTH - 1, 0, PANEL_HEIGHT - 1, 0, 1'b0, 0, 0));
      // reversed ends, one run clipped at both ends, runs wholly off the panel, a clipped vertical run
      send_request(make_req(OP_HRUN, 100, 3, 5, 0, 1'b0, 0, 0));
      send_request(make_req(OP_HRUN, -32768, 32767, PANEL_HEIGHT - 1, 0, 1'b1, 0, 0));
      send_request(make_req(OP_HRUN, PANEL_WIDTH, 300, 7, 0, 1'b1, 0, 0));
      send_request(make_req(OP_HRUN, -1, -5, 7, 0, 1'b1, 0, 0));
      send_request(make_req(OP_VRUN, 0, 0, PANEL_HEIGHT - 1, -32768, 1'b0, 0, 0));
      send_request(make_req(OP_VRUN, 9, 0, -2, -40, 1'b1, 0, 0));
      send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0, 0, 0));
      send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0, 0, STORE_LEN - 1));
   endtask

   task automatic test_fill_extremes();
      send_request(make_req(OP_FILL, 0, 0, 0, 0, 1'b0, 8'hFF, 0));
      send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0, 0, $urandom_range(0, STORE_LEN - 1)));
      send_request(make_req(OP_HRUN, 2, 13, 0, 0, 1'b0, 0, 0));
      send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0, 0, 1));
      send_request(make_req(OP_FILL, 0, 0, 0, 0, 1'b1, 8'h00, 0));
      send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0, 0, $urandom_range(0, STORE_LEN - 1)));
   endtask

   task automatic test_random_mix(int n);
      repeat (n) send_request(random_request());
   endtask

   // sender holds off until the engine has answered everything
   task automatic test_drain_pause();
      repeat (10) send_request(random_request());
      wait_all_answered();
      repeat (10) send_request(random_request());
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (40) send_request(random_request());
      steady = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = '0;
      req_x_start    = '0;
      req_x_end      = '0;
      req_y_start    = '0;
      req_y_end      = '0;
      req_pixel_on   = 1'b0;
      req_fill_value = '0;
      req_byte_index = '0;
      rsp_stall      = 1'b0;
      steady         = 1'b0;
      rsp_taken      = 1'b0;
      stall_left     = 0;
      last_touched   = 0;
      error_count    = 0;
      checked_count  = 0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_fill_extremes();
      test_random_mix(180);
      test_drain_pause();
      test_back_to_back();
      test_random_mix(180);

      wait_all_answered();
      repeat (16) @(negedge clock);
      $display("requests: %0d point, %0d horizontal run, %0d vertical run, %0d fill,",
               op_count[OP_POINT], op_count[OP_HRUN], op_count[OP_VRUN], op_count[OP_FILL]);
      $display("  %0d read, %0d unknown op; %0d responses compared",
               op_count[OP_READ], op_count[5] + op_count[6] + op_count[7], checked_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
